@@ src/hpa_pkg.sv @@
// Shared constants, codes and inter-module structs for the handle pool allocator.
`timescale 1ns / 1ps

package hpa_pkg;

   // Pool geometry. The free queue and the in-use map both hold one entry per handle.
   localparam int POOL_SIZE = 256;
   localparam int HANDLE_W  = 8;
   localparam int CMD_W     = 2;
   localparam int STATUS_W  = 2;
   localparam int ADDR_W    = $clog2(POOL_SIZE);
   localparam int CNT_W     = $clog2(POOL_SIZE + 1);

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC     = 2'd0,
      CMD_TRY_ALLOC = 2'd1,
      CMD_RELEASE   = 2'd2,
      CMD_NOP       = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 2'd0,
      ST_NONE_FREE  = 2'd1,
      ST_EXHAUSTED  = 2'd2,
      ST_NOT_IN_USE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PH_CLEAR,
      PH_IDLE,
      PH_EXEC
   } phase_type;

   typedef struct packed {
      logic                rd_en;
      logic                pop;
      logic                push;
      logic [HANDLE_W-1:0] push_data;
   } fifo_req_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] rd_data;
      logic [CNT_W-1:0]    count;
   } fifo_rsp_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic              wr_data;
   } map_req_type;

   typedef struct packed {
      logic rd_bit;
      logic busy;
   } map_rsp_type;

endpackage

@@ src/hpa_req_if.sv @@
// Command channel of the handle pool allocator: valid, ready and the command beat.
`timescale 1ns / 1ps

interface hpa_req_if;
   logic                        valid;
   logic                        ready;
   logic [hpa_pkg::CMD_W-1:0]    cmd;
   logic [hpa_pkg::HANDLE_W-1:0] handle;

   modport source (output valid, output cmd, output handle, input ready);
   modport sink   (input valid, input cmd, input handle, output ready);
endinterface

@@ src/hpa_rsp_if.sv @@
// Result channel of the handle pool allocator: valid, ready and the result beat.
`timescale 1ns / 1ps

interface hpa_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [hpa_pkg::HANDLE_W-1:0] granted_handle;
   logic [hpa_pkg::STATUS_W-1:0] status;
   logic                         none_in_use;
   logic                         queue_empty;

   modport source (output valid, output granted_handle, output status,
                   output none_in_use, output queue_empty, input ready);
   modport sink   (input valid, input granted_handle, input status,
                   input none_in_use, input queue_empty, output ready);
endinterface

@@ src/hpa_free_fifo.sv @@
// Free queue: released handles in a circular memory with head, tail and count.
`timescale 1ns / 1ps

module hpa_free_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  hpa_pkg::fifo_req_type fifo_req,
   output hpa_pkg::fifo_rsp_type fifo_rsp
);
   import hpa_pkg::*;

   logic [HANDLE_W-1:0] mem [POOL_SIZE];
   logic [HANDLE_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]   head_ff, head_in;
   logic [ADDR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (fifo_req.pop) begin
         head_in  = (head_ff == ADDR_W'(POOL_SIZE - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
      if (fifo_req.push) begin
         tail_in  = (tail_ff == ADDR_W'(POOL_SIZE - 1)) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_req.push) begin
         mem[tail_ff] <= fifo_req.push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_req.rd_en) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   assign fifo_rsp.rd_data = rd_data_ff;
   assign fifo_rsp.count   = count_ff;

`ifndef SYNTHESIS
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      fifo_req.pop |-> count_ff != '0)
      else $error("free queue popped while empty");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      fifo_req.push |-> count_ff != CNT_W'(POOL_SIZE))
      else $error("free queue pushed while full");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(POOL_SIZE))
      else $error("free queue count out of range");
`endif

endmodule

@@ src/hpa_use_map.sv @@
// In-use map: one bit per handle in a memory, swept to zero after reset.
`timescale 1ns / 1ps

module hpa_use_map (
   input  logic                 clock,
   input  logic                 reset,
   input  hpa_pkg::map_req_type map_req,
   output hpa_pkg::map_rsp_type map_rsp
);
   import hpa_pkg::*;

   logic              mem [POOL_SIZE];
   logic              rd_bit_ff;
   logic              busy_ff, busy_in;
   logic [ADDR_W-1:0] clr_idx_ff, clr_idx_in;

   always_comb begin
      busy_in    = busy_ff;
      clr_idx_in = clr_idx_ff;
      if (busy_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == ADDR_W'(POOL_SIZE - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         clr_idx_ff <= '0;
      end else begin
         busy_ff    <= busy_in;
         clr_idx_ff <= clr_idx_in;
      end
   end

   // The sweep owns the write port until every entry has been cleared.
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_idx_ff] <= 1'b0;
      end else if (map_req.wr_en) begin
         mem[map_req.wr_addr] <= map_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (map_req.rd_en) begin
         rd_bit_ff <= mem[map_req.rd_addr];
      end
   end

   assign map_rsp.rd_bit = rd_bit_ff;
   assign map_rsp.busy   = busy_ff;

`ifndef SYNTHESIS
   a_no_access_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !map_req.wr_en && !map_req.rd_en)
      else $error("in-use map accessed during the clearing sweep");
   a_sweep_ends: assert property (@(posedge clock) disable iff (reset)
      busy_ff && clr_idx_ff == ADDR_W'(POOL_SIZE - 1) |=> !busy_ff)
      else $error("clearing sweep did not end after the last entry");
   a_busy_stays_low: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |=> !busy_ff)
      else $error("clearing sweep restarted without reset");
`endif

endmodule

@@ src/handle_pool_allocator.sv @@
// Top level of the handle pool allocator: command sequencer, counters and result register.
`timescale 1ns / 1ps

// The block hands out and takes back 8-bit handles. Commands arrive as beats on the
// req_if channel (allocate, try-allocate, release, or an unused code that does nothing)
// and each command yields exactly one result beat on rsp_if, in order.
// Released handles go to the tail of a FIFO free queue and are reused oldest first;
// allocate mints a fresh handle in ascending order when the queue is empty.
// A command runs in an accept phase and an execute phase: the accept edge reads the
// free-queue memory at the head and the in-use map memory at the requested handle, and
// the edge that completes the execute phase writes both memories back and loads the
// result register. The block takes no new command until the current one has completed.
// rsp_if is driven straight from the result register.
// After reset the in-use map is swept to zero, one entry per cycle, and req_if.ready
// stays low until the sweep has finished.
// The result register frees the command side from the result side: a command is
// accepted while a finished result still waits. If the receiver stalls, the next
// command holds in its execute phase, with no memory written, until the result
// register is taken, and req_if.ready stays low meanwhile.
module handle_pool_allocator (
   input  logic       clock,
   input  logic       reset,
   hpa_req_if.sink    req_if,
   hpa_rsp_if.source  rsp_if
);
   import hpa_pkg::*;

   phase_type    phase_ff, phase_in;
   fifo_req_type fifo_req;
   fifo_rsp_type fifo_rsp;
   map_req_type  map_req;
   map_rsp_type  map_rsp;

   // Command held for its execute phase.
   cmd_type             cmd_ff;
   logic [HANDLE_W-1:0] handle_ff;

   logic [CNT_W-1:0] next_fresh_ff, next_fresh_in;
   logic [CNT_W-1:0] in_use_cnt_ff, in_use_cnt_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [HANDLE_W-1:0] granted_ff;
   status_type          status_ff;
   logic                none_in_use_ff;
   logic                queue_empty_ff;

   logic req_fire;
   logic exec_fire;

   // Decisions of the execute phase, before gating by exec_fire.
   logic [HANDLE_W-1:0] granted_c;
   status_type          status_c;
   logic                pop_c;
   logic                push_c;
   logic                mark_c;
   logic                unmark_c;
   logic [ADDR_W-1:0]   mark_addr_c;
   logic                mint_c;
   logic                handle_ok_c;
   logic [CNT_W-1:0]    q_count_after;

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_CLEAR: if (!map_rsp.busy) phase_in = PH_IDLE;
         PH_IDLE:  if (req_fire) phase_in = PH_EXEC;
         PH_EXEC:  if (exec_fire) phase_in = PH_IDLE;
         default:  phase_in = PH_CLEAR;
      endcase
   end

   // Phase outputs.
   always_comb begin
      req_if.ready = 1'b0;
      exec_fire    = 1'b0;
      unique case (phase_ff)
         PH_CLEAR: ;
         PH_IDLE:  req_if.ready = 1'b1;
         PH_EXEC:  exec_fire = !rsp_valid_ff || rsp_if.ready;
         default:  ;
      endcase
   end

   assign req_fire = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_CLEAR;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff    <= cmd_type'(req_if.cmd);
         handle_ff <= req_if.handle;
      end
   end

   // Command evaluation from the data read at the accept edge.
   always_comb begin
      granted_c   = '0;
      status_c    = ST_OK;
      pop_c       = 1'b0;
      push_c      = 1'b0;
      mark_c      = 1'b0;
      unmark_c    = 1'b0;
      mint_c      = 1'b0;
      mark_addr_c = ADDR_W'(handle_ff);
      handle_ok_c = (CNT_W'(handle_ff) < CNT_W'(POOL_SIZE)) && map_rsp.rd_bit;
      unique case (cmd_ff)
         CMD_ALLOC, CMD_TRY_ALLOC: begin
            if (fifo_rsp.count != '0) begin
               granted_c   = fifo_rsp.rd_data;
               pop_c       = 1'b1;
               mark_c      = 1'b1;
               mark_addr_c = ADDR_W'(fifo_rsp.rd_data);
            end else if (cmd_ff == CMD_TRY_ALLOC) begin
               status_c = ST_NONE_FREE;
            end else if (next_fresh_ff < CNT_W'(POOL_SIZE)) begin
               granted_c   = HANDLE_W'(next_fresh_ff);
               mint_c      = 1'b1;
               mark_c      = 1'b1;
               mark_addr_c = ADDR_W'(next_fresh_ff);
            end else begin
               status_c = ST_EXHAUSTED;
            end
         end
         CMD_RELEASE: begin
            if (handle_ok_c) begin
               unmark_c = 1'b1;
               push_c   = 1'b1;
            end else begin
               status_c = ST_NOT_IN_USE;
            end
         end
         CMD_NOP: ;
         default: ;
      endcase
   end

   // Memory requests: reads at the accept edge, writes at the completing edge.
   always_comb begin
      fifo_req.rd_en     = req_fire;
      fifo_req.pop       = exec_fire && pop_c;
      fifo_req.push      = exec_fire && push_c;
      fifo_req.push_data = handle_ff;

      map_req.rd_en   = req_fire;
      map_req.rd_addr = ADDR_W'(req_if.handle);
      map_req.wr_en   = exec_fire && (mark_c || unmark_c);
      map_req.wr_addr = mark_addr_c;
      map_req.wr_data = mark_c;
   end

   always_comb begin
      next_fresh_in = next_fresh_ff;
      in_use_cnt_in = in_use_cnt_ff;
      if (exec_fire) begin
         if (mint_c) next_fresh_in = next_fresh_ff + 1'b1;
         if (mark_c) in_use_cnt_in = in_use_cnt_ff + 1'b1;
         if (unmark_c) in_use_cnt_in = in_use_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_fresh_ff <= '0;
         in_use_cnt_ff <= '0;
      end else begin
         next_fresh_ff <= next_fresh_in;
         in_use_cnt_ff <= in_use_cnt_in;
      end
   end

   // Queue occupancy once this command has taken effect.
   always_comb begin
      q_count_after = fifo_rsp.count;
      if (pop_c) q_count_after = fifo_rsp.count - 1'b1;
      if (push_c) q_count_after = fifo_rsp.count + 1'b1;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         granted_ff     <= granted_c;
         status_ff      <= status_c;
         none_in_use_ff <= (in_use_cnt_in == '0);
         queue_empty_ff <= (q_count_after == '0);
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.granted_handle = granted_ff;
   assign rsp_if.status         = status_ff;
   assign rsp_if.none_in_use    = none_in_use_ff;
   assign rsp_if.queue_empty    = queue_empty_ff;

   hpa_free_fifo u_free_fifo (
      .clock    (clock),
      .reset    (reset),
      .fifo_req (fifo_req),
      .fifo_rsp (fifo_rsp)
   );

   hpa_use_map u_use_map (
      .clock   (clock),
      .reset   (reset),
      .map_req (map_req),
      .map_rsp (map_rsp)
   );

`ifndef SYNTHESIS
   // Every minted handle is either in use or waiting in the free queue.
   a_handle_conservation: assert property (@(posedge clock) disable iff (reset)
      (CNT_W + 1)'(in_use_cnt_ff) + (CNT_W + 1)'(fifo_rsp.count)
         == (CNT_W + 1)'(next_fresh_ff))
      else $error("minted handles are not all accounted for");
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> phase_ff == PH_EXEC && !req_if.ready)
      else $error("accepted command did not enter its second cycle");
   a_grant_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != ST_OK |-> granted_ff == '0)
      else $error("nonzero handle reported with a failing status");
   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      map_rsp.busy |-> !req_if.ready)
      else $error("command accepted during the clearing sweep");
`endif

endmodule

@@ bench/handle_pool_checker.sv @@
// Checker for the handle pool allocator: predicts every result beat and compares it.
`timescale 1ns / 1ps

module handle_pool_checker (
   input  logic                            clock,
   input  logic                            reset,
   hpa_req_if                              req_mon,
   hpa_rsp_if                              rsp_mon,
   output int                              results_owed,
   output int                              mismatch_count,
   output logic [hpa_pkg::POOL_SIZE-1:0]   held_map
);
   import hpa_pkg::*;

   typedef struct packed {
      logic [HANDLE_W-1:0] granted_handle;
      status_type          status;
      logic                none_in_use;
      logic                queue_empty;
   } grant_result_type;

   // Shadow copy of the pool.
   logic [HANDLE_W-1:0]  recycled[$];
   logic [POOL_SIZE-1:0] held;
   int unsigned          minted;
   int unsigned          held_count;
   grant_result_type     owed_results[$];
   int                   fails;

   // Applies one command to the shadow pool and returns the result it must produce.
   function automatic grant_result_type grant_or_release(cmd_type op,
                                                         logic [HANDLE_W-1:0] h);
      grant_result_type r;
      r = '0;
      r.status = ST_OK;
      case (op)
         CMD_ALLOC, CMD_TRY_ALLOC: begin
            if (recycled.size() > 0) begin
               r.granted_handle = recycled.pop_front();
               held[r.granted_handle] = 1'b1;
               held_count++;
            end else if (op == CMD_TRY_ALLOC) begin
               r.status = ST_NONE_FREE;
            end else if (minted < POOL_SIZE) begin
               r.granted_handle = minted[HANDLE_W-1:0];
               minted++;
               held[r.granted_handle] = 1'b1;
               held_count++;
            end else begin
               r.status = ST_EXHAUSTED;
            end
         end
         CMD_RELEASE: begin
            if (held[h]) begin
               held[h] = 1'b0;
               held_count--;
               recycled.push_back(h);
            end else begin
               r.status = ST_NOT_IN_USE;
            end
         end
         default: ;
      endcase
      r.none_in_use = (held_count == 0);
      r.queue_empty = (recycled.size() == 0);
      return r;
   endfunction

   task automatic check_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin : watch
      grant_result_type want;
      if (reset) begin
         recycled.delete();
         owed_results.delete();
         held = '0;
         minted = 0;
         held_count = 0;
         fails = 0;
      end else begin
         // A result is registered only after its command has been accepted, so the
         // result side can be handled first.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (owed_results.size() == 0) begin
               $display("%0t ns: result beat with none expected, actual handle %0d status %0d",
                        $time, rsp_mon.granted_handle, rsp_mon.status);
               fails++;
            end else begin
               want = owed_results.pop_front();
               check_field("granted_handle", want.granted_handle, rsp_mon.granted_handle);
               check_field("status", want.status, rsp_mon.status);
               check_field("none_in_use", want.none_in_use, rsp_mon.none_in_use);
               check_field("queue_empty", want.queue_empty, rsp_mon.queue_empty);
            end
         end
         if (req_mon.valid && req_mon.ready)
            owed_results.push_back(grant_or_release(cmd_type'(req_mon.cmd), req_mon.handle));
      end
      results_owed   <= owed_results.size();
      mismatch_count <= fails;
      held_map       <= held;
   end

endmodule

@@ bench/tb_handle_pool_allocator.sv @@
// Top of the handle pool allocator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_handle_pool_allocator;
   import hpa_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hpa_req_if req_if ();
   hpa_rsp_if rsp_if ();

   int                   results_owed;
   int                   mismatch_count;
   logic [POOL_SIZE-1:0] held_map;

   // When clear, the command side offers a beat on every cycle it can.
   bit sender_idles = 1'b1;

   handle_pool_allocator i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // The checker sees both channels and predicts every result on its own.
   handle_pool_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .results_owed   (results_owed),
      .mismatch_count (mismatch_count),
      .held_map       (held_map)
   );

   always #10 clock = ~clock;

   // Offers one command beat and returns once it has been accepted. Random idle
   // cycles go in front of the beat, so gaps land in both the accept and the execute
   // phase of the block's command slot. Valid stays high afterward, which lets the next
   // beat follow back to back.
   task automatic offer_command(cmd_type op, logic [HANDLE_W-1:0] h);
      while (sender_idles && $urandom_range(99) < 13) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.cmd    <= op;
      req_if.handle <= h;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Stops offering, waits until every predicted result has come back, and then lets
   // the result register settle.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // Result side. It stalls at random, except for a stretch of beats where it
   // takes everything. Once, early in the fill phase, it refuses results for a
   // long stretch so that the result register fills and the block has to stall
   // its command side while the sender keeps offering.
   initial begin : result_taker
      int  beats;
      bit  long_stall_done;
      beats = 0;
      long_stall_done = 1'b0;
      forever begin
         if (!long_stall_done && beats >= 40) begin
            long_stall_done = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (150) @(posedge clock);
         end
         rsp_if.ready <= (beats >= 300 && beats < 450) || ($urandom_range(99) >= 13);
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready)
            beats++;
      end
   end

   initial begin : stimulus
      logic [HANDLE_W-1:0] order[POOL_SIZE];
      logic [HANDLE_W-1:0] tmp;
      int                  j;
      int                  roll;
      int                  start;
      cmd_type             op;
      logic [HANDLE_W-1:0] pick;

      req_if.valid  <= 1'b0;
      req_if.cmd    <= CMD_NOP;
      req_if.handle <= '0;
      reset         <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The block sweeps its in-use map after reset and holds
      // ready low meanwhile; offer_command simply waits for the handshake.
      offer_command(CMD_RELEASE, 8'h00);     // release of a handle that was never given out
      offer_command(CMD_TRY_ALLOC, 8'hFF);   // nothing queued: none free, no fresh handle
      offer_command(CMD_NOP, 8'h00);         // unused command code only reports flags
      offer_command(CMD_ALLOC, 8'hFF);       // fresh handle 0
      offer_command(CMD_ALLOC, 8'h00);       // fresh handle 1
      offer_command(CMD_RELEASE, 8'hFF);     // top handle, not in use
      offer_command(CMD_RELEASE, 8'h00);     // handle 0 goes to the free queue
      offer_command(CMD_RELEASE, 8'h00);     // double release
      offer_command(CMD_TRY_ALLOC, 8'h55);   // takes handle 0 back from the queue
      offer_command(CMD_RELEASE, 8'h01);
      offer_command(CMD_ALLOC, 8'hAA);       // reuses handle 1 rather than minting
      offer_command(CMD_RELEASE, 8'hAA);     // alternating bit patterns, not in use
      offer_command(CMD_RELEASE, 8'h55);
      offer_command(CMD_NOP, 8'hFF);
      // The sender pauses here until every result is back.
      wait_drained();

      // Fill: mint every remaining handle, then run into the exhausted pool.
      // The long result stall falls in this phase.
      for (int n = 0; n < 257; n++)
         offer_command(CMD_ALLOC, HANDLE_W'($urandom));
      offer_command(CMD_TRY_ALLOC, HANDLE_W'($urandom));
      wait_drained();

      // Drain: hand back all handles in a shuffled order with no idle cycles.
      // The free queue ends up holding the whole pool and its tail wraps.
      for (int n = 0; n < POOL_SIZE; n++)
         order[n] = HANDLE_W'(n);
      for (int n = POOL_SIZE - 1; n > 0; n--) begin
         j = $urandom_range(n);
         tmp = order[n];
         order[n] = order[j];
         order[j] = tmp;
      end
      sender_idles = 1'b0;
      for (int n = 0; n < POOL_SIZE; n++)
         offer_command(CMD_RELEASE, order[n]);
      sender_idles = 1'b1;

      // Churn: mostly allocations, so the oldest released handles come out
      // first. Most releases target a handle that the checker last saw in use;
      // the rest are random and may hit a free one.
      for (int n = 0; n < 180; n++) begin
         roll = $urandom_range(99);
         if (roll < 66)
            op = CMD_ALLOC;
         else if (roll < 78)
            op = CMD_TRY_ALLOC;
         else if (roll < 96)
            op = CMD_RELEASE;
         else
            op = CMD_NOP;
         pick = HANDLE_W'($urandom);
         if (op == CMD_RELEASE && roll < 93) begin
            start = pick;
            for (int k = 0; k < POOL_SIZE; k++) begin
               if (held_map[(start + k) % POOL_SIZE]) begin
                  pick = HANDLE_W'(start + k);
                  break;
               end
            end
         end
         offer_command(op, pick);
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && results_owed == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Watchdog. Ends a hung run with a failure verdict.
   initial begin : watchdog
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
